[src/lage_pkg.sv]
`timescale 1ns / 1ps

package lage_pkg;

    // Request codes carried by an input item
    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_ADVANCE = 2'd2
    } req_type_e_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ROWS_IN_USE    = 3'd0,
        CFG_COLS_IN_USE    = 3'd1,
        CFG_ALIVE_VALUE    = 3'd2,
        CFG_UNDERPOP_LIMIT = 3'd3,
        CFG_OVERPOP_LIMIT  = 3'd4,
        CFG_BIRTH_COUNT    = 3'd5
    } cfg_index_e_t;

    localparam logic [6:0] ROWS_RESET     = 7'd64;
    localparam logic [6:0] COLS_RESET     = 7'd64;
    localparam logic [7:0] ALIVE_RESET    = 8'd255;
    localparam logic [3:0] UNDERPOP_RESET = 4'd2;
    localparam logic [3:0] OVERPOP_RESET  = 4'd3;
    localparam logic [3:0] BIRTH_RESET    = 4'd3;

    // Live configuration seen by the engine
    typedef struct packed {
        logic [6:0] rows_in_use;
        logic [6:0] cols_in_use;
        logic [7:0] alive_value;
        logic [3:0] underpop_limit;
        logic [3:0] overpop_limit;
        logic [3:0] birth_count;
    } cfg_t;

    // Tag of one sweep step, issued alongside the board read
    typedef struct packed {
        logic valid;
        logic col_real;
        logic row_ge1;
        logic row_ge2;
        logic cell_region;
        logic ctr_valid;
        logic ctr_region;
    } step_t;

    // Window status handed to the sequencer and the rule unit
    typedef struct packed {
        logic       busy;
        logic       ctr_valid;
        logic       ctr_region;
        logic       alive;
        logic [7:0] nbr;
    } win_t;

endpackage

[src/lage_cfg.sv]
`timescale 1ns / 1ps

module lage_cfg
    import lage_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and update the addressed field
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROWS_IN_USE:    cfg_next.rows_in_use    = cfg_wr_data[6:0];
                CFG_COLS_IN_USE:    cfg_next.cols_in_use    = cfg_wr_data[6:0];
                CFG_ALIVE_VALUE:    cfg_next.alive_value    = cfg_wr_data;
                CFG_UNDERPOP_LIMIT: cfg_next.underpop_limit = cfg_wr_data[3:0];
                CFG_OVERPOP_LIMIT:  cfg_next.overpop_limit  = cfg_wr_data[3:0];
                CFG_BIRTH_COUNT:    cfg_next.birth_count    = cfg_wr_data[3:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rows_in_use    <= ROWS_RESET;
            cfg_reg.cols_in_use    <= COLS_RESET;
            cfg_reg.alive_value    <= ALIVE_RESET;
            cfg_reg.underpop_limit <= UNDERPOP_RESET;
            cfg_reg.overpop_limit  <= OVERPOP_RESET;
            cfg_reg.birth_count    <= BIRTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/lage_board.sv]
`timescale 1ns / 1ps

module lage_board #(
    parameter int CELL_BITS = 8,
    parameter int DEPTH     = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic                     wr_bank,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [CELL_BITS-1:0]     wr_data,
    input  logic                     rd_en,
    input  logic                     rd_bank,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [CELL_BITS-1:0]     rd_data
);

    logic [CELL_BITS-1:0] bank0_mem [DEPTH];
    logic [CELL_BITS-1:0] bank1_mem [DEPTH];
    logic [CELL_BITS-1:0] rd0_reg;
    logic [CELL_BITS-1:0] rd1_reg;
    logic                 rsel_reg;

    // Write the selected bank
    always_ff @(posedge aclk) begin
        if (wr_en && !wr_bank) begin
            bank0_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_bank) begin
            bank1_mem[wr_addr] <= wr_data;
        end
    end

    // Read both banks, hold the data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd0_reg  <= bank0_mem[rd_addr];
            rd1_reg  <= bank1_mem[rd_addr];
            rsel_reg <= rd_bank;
        end
    end

    assign rd_data = rsel_reg ? rd1_reg : rd0_reg;

endmodule

[src/lage_window.sv]
`timescale 1ns / 1ps

module lage_window
    import lage_pkg::*;
#(
    parameter int MAX_COLS  = 64,
    parameter int CELL_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  step_t                       step,
    input  logic [$clog2(MAX_COLS)-1:0] step_col,
    input  logic [CELL_BITS-1:0]        cell_rdata,
    input  logic [CELL_BITS-1:0]        live_cell,
    output win_t                        win,
    output logic [CELL_BITS-1:0]        ctr_value
);

    localparam int CIW = $clog2(MAX_COLS);

    // Line buffers: previous row keeps value and alive bit, the row before keeps alive only
    logic [CELL_BITS:0]   lb1_mem [MAX_COLS];
    logic                 lb2_mem [MAX_COLS];
    logic [CELL_BITS:0]   lb1_rd_reg;
    logic                 lb2_rd_reg;

    step_t                s1_reg;
    logic [CIW-1:0]       s1_col_reg;

    // Window columns: [2] upper row, [1] centre row, [0] lower row
    logic [2:0]           w0_reg;
    logic [2:0]           w1_reg;
    logic [2:0]           w2_reg;
    logic [CELL_BITS-1:0] v1_reg;
    logic [CELL_BITS-1:0] v2_reg;

    logic                 s2_valid_reg;
    logic                 s2_ctr_valid_reg;
    logic                 s2_ctr_region_reg;

    logic                 a_new;
    logic [2:0]           col_in;

    // Read the line buffers alongside the board read
    always_ff @(posedge aclk) begin
        if (step.valid && step.col_real) begin
            lb1_rd_reg <= lb1_mem[step_col];
            lb2_rd_reg <= lb2_mem[step_col];
        end
    end

    // Form the incoming column; rows above the board read as dead
    always_comb begin
        a_new     = s1_reg.cell_region && (cell_rdata == live_cell);
        col_in[0] = s1_reg.col_real && a_new;
        col_in[1] = s1_reg.col_real && s1_reg.row_ge1 && lb1_rd_reg[0];
        col_in[2] = s1_reg.col_real && s1_reg.row_ge2 && lb2_rd_reg;
    end

    // Push the current row down the line buffers
    always_ff @(posedge aclk) begin
        if (s1_reg.valid && s1_reg.col_real) begin
            lb1_mem[s1_col_reg] <= {cell_rdata, a_new};
            lb2_mem[s1_col_reg] <= lb1_rd_reg[0];
        end
    end

    // Shift the window one column along
    always_ff @(posedge aclk) begin
        s1_col_reg <= step_col;
        if (s1_reg.valid) begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
            w2_reg <= col_in;
            v1_reg <= v2_reg;
            v2_reg <= lb1_rd_reg[CELL_BITS:1];
        end
    end

    // Control pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg            <= '0;
            s2_valid_reg      <= 1'b0;
            s2_ctr_valid_reg  <= 1'b0;
            s2_ctr_region_reg <= 1'b0;
        end else begin
            s1_reg            <= step;
            s2_valid_reg      <= s1_reg.valid;
            s2_ctr_valid_reg  <= s1_reg.valid && s1_reg.ctr_valid;
            s2_ctr_region_reg <= s1_reg.valid && s1_reg.ctr_region;
        end
    end

    always_comb begin
        win.busy       = s1_reg.valid || s2_valid_reg;
        win.ctr_valid  = s2_ctr_valid_reg;
        win.ctr_region = s2_ctr_region_reg;
        win.alive      = w1_reg[1];
        win.nbr        = {w0_reg, w2_reg, w1_reg[2], w1_reg[0]};
    end

    assign ctr_value = v1_reg;

endmodule

[src/lage_rule.sv]
`timescale 1ns / 1ps

module lage_rule #(
    parameter int CELL_BITS = 8
) (
    input  logic [7:0]           nbr,
    input  logic                 alive,
    input  logic [CELL_BITS-1:0] value,
    input  logic [CELL_BITS-1:0] live_cell,
    input  logic [3:0]           underpop_limit,
    input  logic [3:0]           overpop_limit,
    input  logic [3:0]           birth_count,
    output logic [CELL_BITS-1:0] next_value
);

    logic [3:0] n;

    // Count live neighbours
    always_comb begin
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(nbr[i]);
        end
    end

    // Apply the rules in priority order; anything else fades
    always_comb begin
        if (alive && (n < underpop_limit)) begin
            next_value = live_cell >> 1;
        end else if (alive && (n > overpop_limit)) begin
            next_value = live_cell >> 1;
        end else if (!alive && (n == birth_count)) begin
            next_value = live_cell;
        end else if (alive && (n >= underpop_limit) && (n <= birth_count)) begin
            next_value = live_cell;
        end else begin
            next_value = value >> 1;
        end
    end

endmodule

[src/life_automaton_generation_engine_core.sv]
`timescale 1ns / 1ps
// Channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// input     | s_valid / s_ready      | s_req_type, s_row, s_col, s_cell_in
// result    | m_valid / m_ready      | m_cell_out (one item per read request)
// config    | cfg_wr_en              | cfg_index, cfg_wr_data
//
// Write and unknown requests are handled on acceptance; a read first passes through ST_RDOUT, its result then sits in
// the output register while further items are accepted.
// An advance sweeps (MAX_ROWS+1)*(MAX_COLS+1) positions, one position per cycle
// through a single rule unit, then waits in ST_DRAIN until the window is empty.
// After reset a clearing pass zeroes bank 0, all MAX_ROWS*MAX_COLS cells (4096).
// A second read waits before the output register frees only when m_ready is low.

module life_automaton_generation_engine_core
    import lage_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int CELL_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [5:0] s_row,
    input  logic [5:0] s_col,
    input  logic [7:0] s_cell_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cell_out,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wr_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RCMP  = (RW > 7) ? RW : 7;
    localparam int CCMP  = (CW > 7) ? CW : 7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDOUT,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [RW-1:0]        rr_reg, rr_next;
    logic [CW-1:0]        cc_reg, cc_next;
    logic [AW-1:0]        rd_addr_reg, rd_addr_next;
    logic [AW-1:0]        wr_cnt_reg, wr_cnt_next;
    logic                 bank_reg, bank_next;
    logic                 rd_inside_reg, rd_inside_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_cell_out_reg, m_cell_out_next;

    cfg_t                 cfg;
    step_t                step;
    win_t                 win;
    logic [CELL_BITS-1:0] ctr_value;
    logic [CELL_BITS-1:0] rule_value;

    logic [RCMP-1:0]      rows_ext, nr;
    logic [CCMP-1:0]      cols_ext, nc;
    logic [RCMP-1:0]      rr_ext;
    logic [CCMP-1:0]      cc_ext;
    logic                 row_real, col_real;

    logic                 accept;
    logic                 req_inside;
    logic [AW-1:0]        req_addr;
    logic [CELL_BITS+7:0] cell_in_ext;
    logic [CELL_BITS+7:0] alive_ext;
    logic [CELL_BITS+7:0] rdata_ext;
    logic [CELL_BITS-1:0] live_cell;

    logic                 mem_we, mem_wbank, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [CELL_BITS-1:0] mem_wdata, mem_rdata;

    lage_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Saturate the in-use region at the board size
    always_comb begin
        rows_ext = RCMP'(cfg.rows_in_use);
        cols_ext = CCMP'(cfg.cols_in_use);
        nr       = (rows_ext > RCMP'(MAX_ROWS)) ? RCMP'(MAX_ROWS) : rows_ext;
        nc       = (cols_ext > CCMP'(MAX_COLS)) ? CCMP'(MAX_COLS) : cols_ext;
    end

    // Fit external 8-bit values to the cell width
    always_comb begin
        cell_in_ext = {{CELL_BITS{1'b0}}, s_cell_in};
        alive_ext   = {{CELL_BITS{1'b0}}, cfg.alive_value};
        rdata_ext   = {8'd0, mem_rdata};
        live_cell   = alive_ext[CELL_BITS-1:0];
    end

    // Request decode
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign req_inside = (RCMP'(s_row) < nr) && (CCMP'(s_col) < nc);
    assign req_addr   = AW'(32'(s_row) * 32'(MAX_COLS) + 32'(s_col));

    // Sweep step tag: position (rr, cc) is read, centre (rr-1, cc-1) is evaluated
    always_comb begin
        rr_ext           = RCMP'(rr_reg);
        cc_ext           = CCMP'(cc_reg);
        row_real         = (rr_reg != RW'(MAX_ROWS));
        col_real         = (cc_reg != CW'(MAX_COLS));
        step.valid       = (state_reg == ST_SWEEP);
        step.col_real    = col_real;
        step.row_ge1     = (rr_reg != '0);
        step.row_ge2     = (rr_reg >= RW'(2));
        step.cell_region = row_real && col_real && (rr_ext < nr) && (cc_ext < nc);
        step.ctr_valid   = (rr_reg != '0) && (cc_reg != '0);
        step.ctr_region  = step.ctr_valid && (rr_ext <= nr) && (cc_ext <= nc);
    end

    lage_window #(
        .MAX_COLS  (MAX_COLS),
        .CELL_BITS (CELL_BITS)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .step_col   (cc_reg[CIW-1:0]),
        .cell_rdata (mem_rdata),
        .live_cell  (live_cell),
        .win        (win),
        .ctr_value  (ctr_value)
    );

    lage_rule #(
        .CELL_BITS (CELL_BITS)
    ) u_rule (
        .nbr            (win.nbr),
        .alive          (win.alive),
        .value          (ctr_value),
        .live_cell      (live_cell),
        .underpop_limit (cfg.underpop_limit),
        .overpop_limit  (cfg.overpop_limit),
        .birth_count    (cfg.birth_count),
        .next_value     (rule_value)
    );

    // Board write port: clearing pass, sweep results, then cell writes
    always_comb begin
        mem_we    = 1'b0;
        mem_wbank = bank_reg;
        mem_waddr = req_addr;
        mem_wdata = cell_in_ext[CELL_BITS-1:0];
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_wbank = 1'b0;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (win.ctr_valid) begin
            mem_we    = 1'b1;
            mem_wbank = ~bank_reg;
            mem_waddr = wr_cnt_reg;
            mem_wdata = win.ctr_region ? rule_value : '0;
        end else if (accept && (s_req_type == REQ_WRITE) && req_inside) begin
            mem_we    = 1'b1;
        end
    end

    // Board read port: sweep reads, then cell reads
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = req_addr;
        if ((state_reg == ST_SWEEP) && row_real && col_real) begin
            mem_re    = 1'b1;
            mem_raddr = rd_addr_reg;
        end else if (accept && (s_req_type == REQ_READ)) begin
            mem_re    = 1'b1;
        end
    end

    lage_board #(
        .CELL_BITS (CELL_BITS),
        .DEPTH     (CELLS)
    ) u_board (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_bank (mem_wbank),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_bank (bank_reg),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        rr_next         = rr_reg;
        cc_next         = cc_reg;
        rd_addr_next    = rd_addr_reg;
        wr_cnt_next     = wr_cnt_reg;
        bank_next       = bank_reg;
        rd_inside_next  = rd_inside_reg;
        m_valid_next    = m_valid_reg;
        m_cell_out_next = m_cell_out_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Advance the result address with each evaluated centre
        if (win.ctr_valid) begin
            wr_cnt_next = wr_cnt_reg + 1'b1;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_req_type)
                        REQ_READ: begin
                            rd_inside_next = req_inside;
                            state_next     = ST_RDOUT;
                        end
                        REQ_ADVANCE: begin
                            rr_next      = '0;
                            cc_next      = '0;
                            rd_addr_next = '0;
                            wr_cnt_next  = '0;
                            state_next   = ST_SWEEP;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RDOUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_cell_out_next = rd_inside_reg ? rdata_ext[7:0] : 8'd0;
                    state_next      = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (row_real && col_real) begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                if (!col_real) begin
                    cc_next = '0;
                    if (!row_real) begin
                        state_next = ST_DRAIN;
                    end else begin
                        rr_next = rr_reg + 1'b1;
                    end
                end else begin
                    cc_next = cc_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!win.busy) begin
                    bank_next  = ~bank_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            bank_reg    <= bank_next;
            m_valid_reg <= m_valid_next;
        end
        rr_reg         <= rr_next;
        cc_reg         <= cc_next;
        rd_addr_reg    <= rd_addr_next;
        wr_cnt_reg     <= wr_cnt_next;
        rd_inside_reg  <= rd_inside_next;
        m_cell_out_reg <= m_cell_out_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_cell_out = m_cell_out_reg;

    // A new result only ever follows a read waiting for the output register
    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_RDOUT))
        else $error("result appeared without a pending read");

    // The banks swap only when a sweep has fully drained
    a_bank_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (bank_reg != $past(bank_reg)) |-> $past(state_reg == ST_DRAIN))
        else $error("bank swapped outside the end of an advance");

    // Next-board writes occur only while an advance is running
    a_sweep_write: assert property (@(posedge aclk) disable iff (!aresetn)
        win.ctr_valid |-> ((state_reg == ST_SWEEP) || (state_reg == ST_DRAIN)))
        else $error("generation write outside an advance");

endmodule
